### rtl/core/ettm_pkg.sv
// shared types and constants for the execution time monitor
`default_nettype none

package ettm_pkg;

    // segment and timer sizing
    localparam int NUM_SEG   = 2;
    localparam int SEG_W     = 1;
    localparam int TIMER_W   = 32;
    localparam int SHIFT_W   = 5;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(4);

    // command codes
    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ENTER = 2'd1,
        CMD_LEAVE = 2'd2
    } t_cmd;

    // one input item
    typedef struct packed {
        logic [1:0]         command;
        logic [SEG_W-1:0]   segment;
        logic [TIMER_W-1:0] timer_value;
    } t_item;

    // one result item
    typedef struct packed {
        logic               stats_valid;
        logic [SEG_W-1:0]   seg_out;
        logic [TIMER_W-1:0] current_time;
        logic [TIMER_W-1:0] average_time;
        logic [TIMER_W-1:0] minimum_time;
        logic [TIMER_W-1:0] maximum_time;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/ettm_in_stage.sv
// input register stage with stall toward the upstream side
`default_nettype none

module ettm_in_stage (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire ettm_pkg::t_item       i_item,
    input  wire logic                  i_advance,
    output logic                       o_valid,
    output ettm_pkg::t_item            o_item
);

    logic            r_valid;
    logic            n_valid;
    ettm_pkg::t_item r_item;
    logic            load;

    // stage takes a transfer when empty or when its item moves on
    assign load    = !r_valid || i_advance;
    assign o_stall = !load;
    assign n_valid = load ? i_valid : r_valid;

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### rtl/core/ettm_seg_stats.sv
// per-segment statistics store and single-pass update logic
`default_nettype none

module ettm_seg_stats (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_commit,
    input  wire ettm_pkg::t_item               i_item,
    input  wire logic [ettm_pkg::SHIFT_W-1:0]  i_avg_shift,
    output ettm_pkg::t_result                  o_result
);

    logic [ettm_pkg::TIMER_W-1:0] r_enter [ettm_pkg::NUM_SEG];
    logic [ettm_pkg::TIMER_W-1:0] r_avg   [ettm_pkg::NUM_SEG];
    logic [ettm_pkg::TIMER_W-1:0] r_min   [ettm_pkg::NUM_SEG];
    logic [ettm_pkg::TIMER_W-1:0] r_max   [ettm_pkg::NUM_SEG];
    logic [ettm_pkg::NUM_SEG-1:0] r_first;

    logic [ettm_pkg::TIMER_W-1:0] n_enter;
    logic [ettm_pkg::TIMER_W-1:0] n_avg;
    logic [ettm_pkg::TIMER_W-1:0] n_min;
    logic [ettm_pkg::TIMER_W-1:0] n_max;
    logic [ettm_pkg::NUM_SEG-1:0] n_first;

    logic [ettm_pkg::SEG_W-1:0]   seg;
    logic [ettm_pkg::TIMER_W-1:0] cur;
    logic [ettm_pkg::TIMER_W-1:0] avg_base;
    logic [ettm_pkg::TIMER_W:0]   up_diff;
    logic [ettm_pkg::TIMER_W-1:0] dn_diff;
    logic [ettm_pkg::TIMER_W-1:0] step;
    logic                         measure;

    assign seg = i_item.segment;

    // elapsed time on a down-counting timer
    assign cur = r_enter[seg] - i_item.timer_value;

    // leave counts only after a nonzero enter stamp
    assign measure = (ettm_pkg::t_cmd'(i_item.command) == ettm_pkg::CMD_LEAVE)
                     && (r_enter[seg] != '0);

    // average moves toward current by the shifted distance
    assign avg_base = r_first[seg] ? cur : r_avg[seg];
    assign up_diff  = {1'b0, cur} - {1'b0, avg_base};
    assign dn_diff  = avg_base - cur;

    always_comb begin
        if (!up_diff[ettm_pkg::TIMER_W]) begin
            step  = up_diff[ettm_pkg::TIMER_W-1:0] >> i_avg_shift;
        end else begin
            step  = dn_diff >> i_avg_shift;
        end
    end

    // next values for the addressed segment
    always_comb begin
        n_enter = r_enter[seg];
        n_avg   = r_avg[seg];
        n_min   = r_min[seg];
        n_max   = r_max[seg];
        n_first = r_first;
        case (ettm_pkg::t_cmd'(i_item.command))
            ettm_pkg::CMD_INIT: begin
                n_first = '1;
            end
            ettm_pkg::CMD_ENTER: begin
                n_enter = i_item.timer_value;
            end
            ettm_pkg::CMD_LEAVE: begin
                if (measure) begin
                    n_first[seg] = 1'b0;
                    if (!up_diff[ettm_pkg::TIMER_W]) begin
                        n_avg = avg_base + step;
                    end else begin
                        n_avg = avg_base - step;
                    end
                    if (r_first[seg]) begin
                        n_min = cur;
                        n_max = cur;
                    end else if (cur < r_min[seg]) begin
                        n_min = cur;
                    end else if (cur > r_max[seg]) begin
                        n_max = cur;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // state update on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '1;
            for (int i = 0; i < ettm_pkg::NUM_SEG; i++) begin
                r_enter[i] <= '0;
                r_avg[i]   <= '0;
                r_min[i]   <= '0;
                r_max[i]   <= '0;
            end
        end else if (i_commit) begin
            r_first      <= n_first;
            r_enter[seg] <= n_enter;
            r_avg[seg]   <= n_avg;
            r_min[seg]   <= n_min;
            r_max[seg]   <= n_max;
        end
    end

    // result fields reflect the segment after the item
    assign o_result.stats_valid  = measure;
    assign o_result.seg_out      = seg;
    assign o_result.current_time = measure ? cur : '0;
    assign o_result.average_time = n_avg;
    assign o_result.minimum_time = n_min;
    assign o_result.maximum_time = n_max;

endmodule

`default_nettype wire

### rtl/core/exec_time_min_max_avg_monitor.sv
// top level of the execution time min/max/average monitor
// path from input transfer to result: input register, then result register
// throughput: one item per cycle unless the result side stalls, the segment update is a single pass between them
// back-to-back items on one segment see each other's updates in order
// reset: enter stamps and statistics cleared, all segments armed, avg_shift = 4
`default_nettype none

module exec_time_min_max_avg_monitor (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [1:0]                          i_command,
    input  wire logic [ettm_pkg::SEG_W-1:0]          i_segment,
    input  wire logic [ettm_pkg::TIMER_W-1:0]        i_timer_value,
    // result channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_stats_valid,
    output logic [ettm_pkg::SEG_W-1:0]               o_seg_out,
    output logic [ettm_pkg::TIMER_W-1:0]             o_current_time,
    output logic [ettm_pkg::TIMER_W-1:0]             o_average_time,
    output logic [ettm_pkg::TIMER_W-1:0]             o_minimum_time,
    output logic [ettm_pkg::TIMER_W-1:0]             o_maximum_time,
    // configuration channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [ettm_pkg::SHIFT_W-1:0]        i_cfg_data
);

    ettm_pkg::t_item   in_item;
    ettm_pkg::t_item   stage_item;
    ettm_pkg::t_result stats_result;
    ettm_pkg::t_result r_out;
    logic              stage_valid;
    logic              advance;
    logic              commit;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [ettm_pkg::SHIFT_W-1:0] r_avg_shift;

    assign in_item.command     = i_command;
    assign in_item.segment     = i_segment;
    assign in_item.timer_value = i_timer_value;

    // result register moves when empty or when its transfer completes
    assign advance     = !r_out_valid || !i_stall;
    assign commit      = advance && stage_valid;
    assign n_out_valid = advance ? stage_valid : r_out_valid;

    ettm_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    ettm_seg_stats u_seg_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (commit),
        .i_item      (stage_item),
        .i_avg_shift (r_avg_shift),
        .o_result    (stats_result)
    );

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_shift <= ettm_pkg::SHIFT_RESET;
        end else if (i_cfg_valid) begin
            r_avg_shift <= i_cfg_data;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= stats_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_stats_valid  = r_out.stats_valid;
    assign o_seg_out      = r_out.seg_out;
    assign o_current_time = r_out.current_time;
    assign o_average_time = r_out.average_time;
    assign o_minimum_time = r_out.minimum_time;
    assign o_maximum_time = r_out.maximum_time;

endmodule

`default_nettype wire
